FILE: rtl/ansi_color_text_console_unit_assert.svh
// Assertion macros shared by the console checker.
`ifndef ANSI_COLOR_TEXT_CONSOLE_UNIT_ASSERT_SVH
`define ANSI_COLOR_TEXT_CONSOLE_UNIT_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define ACTC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define ACTC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/actc_pkg.sv
// Shared constants, types and helpers of the color text console.
`default_nettype none
package actc_pkg;

  localparam int unsigned MAX_PARAMS  = 5;
  localparam int unsigned PCOUNT_W    = $clog2(MAX_PARAMS + 1);
  localparam logic [7:0]  CELL_WIDTH  = 8'd6;
  localparam logic [7:0]  CELL_HEIGHT = 8'd8;

  localparam logic [7:0] SCREEN_WIDTH_RST  = 8'd160;
  localparam logic [7:0] SCREEN_HEIGHT_RST = 8'd128;

  // Register indexes of the configuration port
  localparam logic CFG_SCREEN_WIDTH  = 1'b0;
  localparam logic CFG_SCREEN_HEIGHT = 1'b1;

  // Character codes
  localparam logic [7:0] CH_NUL    = 8'd0;
  localparam logic [7:0] CH_LF     = 8'd10;
  localparam logic [7:0] CH_ESC    = 8'd27;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_M      = 8'h6D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // SGR foreground codes: black .. cyan map to color indexes 1 .. 7
  localparam logic [7:0] SGR_FG_BLACK    = 8'd30;
  localparam logic [7:0] SGR_FG_CYAN     = 8'd36;
  localparam logic [2:0] COLOR_IDX_WHITE = 3'd0;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_ESC  = 2'd1,
    MODE_SEQ  = 2'd2
  } mode_e;

  typedef struct packed {
    logic       draw;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic [7:0] glyph;
    logic [2:0] color;
  } draw_cmd_t;

  function automatic logic [2:0] color_of(input logic [7:0] code);
    logic [7:0] diff;
    diff = code - (SGR_FG_BLACK - 8'd1);
    if (code inside {[SGR_FG_BLACK:SGR_FG_CYAN]}) begin
      return diff[2:0];
    end
    return COLOR_IDX_WHITE;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/actc_in_stage.sv
// Input register stage of the color text console.
`default_nettype none
module actc_in_stage
  import actc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output      logic       in_ready_o,
  input  wire logic [7:0] char_code_i,
  input  wire logic       take_i,
  output      logic       held_valid_o,
  output      logic [7:0] held_char_o
);

  logic       valid_q, valid_d;
  logic [7:0] char_q;

  // Free slot, or the held byte leaves in this cycle
  assign in_ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      char_q <= char_code_i;
    end
  end

  assign held_valid_o = valid_q;
  assign held_char_o  = char_q;

endmodule
`default_nettype wire

FILE: rtl/actc_engine.sv
// Escape parser, cursor and color state of the color text console.
`default_nettype none
module actc_engine
  import actc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_index_i,
  input  wire logic [7:0] cfg_wdata_i,
  input  wire logic [7:0] char_i,
  input  wire logic       fire_i,
  output      draw_cmd_t  cmd_o
);

  mode_e                mode_q, mode_d;
  logic [7:0]           pval_q, pval_d;
  logic [PCOUNT_W-1:0]  pcnt_q, pcnt_d;
  logic [2:0]           color_q, color_d;
  logic [7:0]           cur_x_q, cur_x_d;
  logic [7:0]           cur_y_q, cur_y_d;
  logic [7:0]           width_q, height_q;

  logic                is_digit, is_semi, is_m, plain;
  logic                last_sep;
  logic [PCOUNT_W-1:0] pcnt_inc;
  logic [7:0]          step_y, nl_y;
  logic                wrap;
  logic [7:0]          draw_x, draw_y;
  logic [2:0]          plain_color;

  assign is_digit = (char_i inside {[CH_ZERO:CH_NINE]});
  assign is_semi  = (char_i == CH_SEMI);
  assign is_m     = (char_i == CH_M);
  assign pcnt_inc = pcnt_q + PCOUNT_W'(1);
  assign last_sep = (pcnt_inc >= PCOUNT_W'(MAX_PARAMS));

  // Bytes that fall through to normal handling
  always_comb begin
    case (mode_q)
      MODE_ESC: plain = (char_i != CH_LBRACK);
      MODE_SEQ: plain = !(is_digit || is_semi || is_m);
      default:  plain = 1'b1;
    endcase
  end

  // Newline target row, with screen wrap
  assign step_y = cur_y_q + CELL_HEIGHT;
  assign nl_y   = (({1'b0, step_y} + {1'b0, CELL_HEIGHT}) > {1'b0, height_q}) ? 8'd0 : step_y;
  assign wrap   = (({1'b0, cur_x_q} + {1'b0, CELL_WIDTH}) > {1'b0, width_q});
  assign draw_x = wrap ? 8'd0 : cur_x_q;
  assign draw_y = wrap ? nl_y : cur_y_q;
  // An aborted sequence falls back to white before drawing
  assign plain_color = (mode_q == MODE_SEQ) ? COLOR_IDX_WHITE : color_q;

  // Next parse mode
  always_comb begin
    mode_d = mode_q;
    if (plain) begin
      mode_d = (char_i == CH_ESC) ? MODE_ESC : MODE_IDLE;
    end else begin
      case (mode_q)
        MODE_ESC: mode_d = MODE_SEQ;
        MODE_SEQ: begin
          if (is_m || (is_semi && last_sep)) begin
            mode_d = MODE_IDLE;
          end
        end
        default: mode_d = MODE_IDLE;
      endcase
    end
  end

  // Parameters, color, cursor and draw command
  always_comb begin
    pval_d  = pval_q;
    pcnt_d  = pcnt_q;
    color_d = color_q;
    cur_x_d = cur_x_q;
    cur_y_d = cur_y_q;
    cmd_o   = '{draw: 1'b0, pos_x: draw_x, pos_y: draw_y, glyph: char_i, color: plain_color};
    if (plain) begin
      color_d = plain_color;
      case (char_i)
        CH_NUL, CH_ESC: ;
        CH_LF: begin
          cur_x_d = 8'd0;
          cur_y_d = nl_y;
        end
        default: begin
          cmd_o.draw = 1'b1;
          cur_x_d    = draw_x + CELL_WIDTH;
          cur_y_d    = draw_y;
        end
      endcase
    end else if (mode_q == MODE_ESC) begin
      pval_d = 8'd0;
      pcnt_d = '0;
    end else if (is_digit) begin
      pval_d = (pval_q << 3) + (pval_q << 1) + {4'd0, char_i[3:0]};
    end else if (is_semi) begin
      pcnt_d = pcnt_inc;
      if (last_sep) begin
        color_d = color_of(pval_q);
      end else begin
        pval_d = 8'd0;
      end
    end else begin
      color_d = color_of(pval_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      pval_q  <= 8'd0;
      pcnt_q  <= '0;
      color_q <= COLOR_IDX_WHITE;
      cur_x_q <= 8'd0;
      cur_y_q <= 8'd0;
    end else if (fire_i) begin
      mode_q  <= mode_d;
      pval_q  <= pval_d;
      pcnt_q  <= pcnt_d;
      color_q <= color_d;
      cur_x_q <= cur_x_d;
      cur_y_q <= cur_y_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SCREEN_WIDTH_RST;
      height_q <= SCREEN_HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SCREEN_WIDTH:  width_q  <= cfg_wdata_i;
        CFG_SCREEN_HEIGHT: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/ansi_color_text_console_unit.sv
// Top level of the color text console: input stage, parser engine, result register.
//
// Usage:
//   Input channel: one character byte per request on char_code_i, taken when
//   in_valid_i and in_ready_o are both high. Byte 0 ends a string, ESC '['
//   opens an SGR color sequence, newline moves to the next text row.
//   Output channel: one draw request (pos_x_o, pos_y_o, glyph_o, color_index_o)
//   per printable byte, taken when out_valid_o and out_ready_i are both high.
//   Configuration: cfg_we_i writes cfg_wdata_i into register cfg_index_i
//   (0 screen_width, 1 screen_height) in the same cycle; write only while idle.
// Timing:
//   A byte lands in the input register at acceptance and is parsed there; its draw
//   request enters the result register when taken. One byte per cycle is sustained
//   unless output stalls, set by the single parse step between the two registers.
// Reset:
//   rst_ni clears the parser, cursor (0,0), color (white) and both valids;
//   screen size returns to 160 x 128.
// Stall:
//   While a draw request waits, bytes that draw nothing keep flowing; the next
//   printable byte holds in the input register until the result slot frees.
`default_nettype none
module ansi_color_text_console_unit
  import actc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_index_i,
  input  wire logic [7:0] cfg_wdata_i,
  input  wire logic       in_valid_i,
  output      logic       in_ready_o,
  input  wire logic [7:0] char_code_i,
  output      logic       out_valid_o,
  input  wire logic       out_ready_i,
  output      logic [7:0] pos_x_o,
  output      logic [7:0] pos_y_o,
  output      logic [7:0] glyph_o,
  output      logic [2:0] color_index_o
);

  logic       held_valid;
  logic [7:0] held_char;
  logic       take;
  draw_cmd_t  cmd;

  logic       out_valid_q, out_valid_d;
  logic [7:0] pos_x_q, pos_y_q, glyph_q;
  logic [2:0] color_q;

  actc_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .char_code_i  (char_code_i),
    .take_i       (take),
    .held_valid_o (held_valid),
    .held_char_o  (held_char)
  );

  actc_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .char_i      (held_char),
    .fire_i      (take),
    .cmd_o       (cmd)
  );

  // Advance the held byte unless it draws and the result slot stays full
  assign take = held_valid && (!cmd.draw || !out_valid_q || out_ready_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (take && cmd.draw) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Load the payload only with a new draw request
  always_ff @(posedge clk_i) begin
    if (take && cmd.draw) begin
      pos_x_q <= cmd.pos_x;
      pos_y_q <= cmd.pos_y;
      glyph_q <= cmd.glyph;
      color_q <= cmd.color;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pos_x_o       = pos_x_q;
  assign pos_y_o       = pos_y_q;
  assign glyph_o       = glyph_q;
  assign color_index_o = color_q;

endmodule
`default_nettype wire

FILE: rtl/actc_checker.sv
// Port-level checker of the color text console and its bind.
`default_nettype none
`include "ansi_color_text_console_unit_assert.svh"
module actc_checker
  import actc_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [7:0] pos_x_o,
  input wire logic [7:0] pos_y_o,
  input wire logic [7:0] glyph_o,
  input wire logic [2:0] color_index_o
);

  // Hold a stalled draw request
  `ACTC_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(pos_x_o) && $stable(pos_y_o) && $stable(glyph_o) && $stable(color_index_o), "stalled draw request changed")
  // Control bytes never produce a draw
  `ACTC_ASSERT(a_no_ctrl_glyph, clk_i, rst_ni, out_valid_o |-> glyph_o != CH_NUL && glyph_o != CH_LF && glyph_o != CH_ESC, "control byte drawn")
  // Rows advance in whole cells, so every row is cell aligned
  `ACTC_ASSERT(a_row_aligned, clk_i, rst_ni, out_valid_o |-> pos_y_o[2:0] == 3'd0, "draw row not cell aligned")
  // Drop any request once a reset edge has been seen
  `ACTC_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> !out_valid_o, "draw request during reset")

endmodule

bind ansi_color_text_console_unit actc_checker u_actc_checker (.*);
`default_nettype wire
